[hdl/tca_pkg.sv]
// shared widths, types and codes for the tetrahedron circumsphere pipeline
`default_nettype none
package tca_pkg;
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int EPS_FRAC   = 24;
    localparam int EPS_W      = 48;
    localparam int CFG_IW     = 8;

    localparam int DW   = COORD_BITS + 1;      // edge vector component
    localparam int PRW  = 2 * DW;              // full product of a pair of edge components
    localparam int XW   = 2 * DW;              // cross product component
    localparam int LW   = 2 * DW;              // squared edge length
    localparam int PPW  = 2 * DW + 2;          // partial product
    localparam int TW   = DW + XW + 1;         // triple product
    localparam int NW   = LW + XW + 2;         // center numerator
    localparam int DENW = TW + 1;              // twice the triple product
    localparam int QB   = COORD_BITS + 2;      // quotient bits
    localparam int RW   = DENW + QB;           // divider remainder
    localparam int QSW  = COORD_BITS + 3;      // signed offset
    localparam int SW   = 2 * QSW;             // sum of squared offsets
    localparam int SQW  = 2 * COORD_BITS;      // root operand
    localparam int OW   = 2 * COORD_BITS + 1;  // root working width
    localparam int DGW  = TW + EPS_FRAC + EPS_W + 3 * FRAC_BITS;

    localparam int GM_LAT  = 8;
    localparam int DIV_LAT = QB + 2;
    localparam int SQ_LAT  = COORD_BITS;
    localparam int TL      = GM_LAT + DIV_LAT + 2 + SQ_LAT + 1;

    localparam int IN_W  = ((12 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int USR_W = 3;

    localparam int FLG_VALID = 0;
    localparam int FLG_ALPHA = 1;
    localparam int FLG_SAT   = 2;

    localparam logic [CFG_IW-1:0] CFG_ALPHA = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_EPS   = CFG_IW'(1);

    localparam logic [COORD_BITS-1:0] ALPHA_RST = COORD_BITS'(256);
    localparam logic [EPS_W-1:0]      EPS_RST   = EPS_W'(16777);

    localparam logic [QB-1:0] OFF_LIM = {1'b1, {(COORD_BITS + 1){1'b0}}};

    // cyclic successors of an axis or edge index
    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]   dif_t;
    typedef logic signed [PRW-1:0]  prd_t;
    typedef logic signed [XW-1:0]   crs_t;
    typedef logic signed [PPW-1:0]  pp_t;
    typedef logic signed [TW-1:0]   tri_t;
    typedef logic signed [NW-1:0]   nsum_t;
    typedef logic [RW-1:0]          rem_t;
    typedef logic [DENW-1:0]        den_t;
    typedef logic [QB-1:0]          quo_t;
    typedef logic signed [QSW-1:0]  off_t;

    typedef struct packed {
        logic [2:0][RW-1:0] num;
        den_t               den;
        logic [2:0]         neg;
        logic               deg;
    } gm_out_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] cen;
        logic                       csat;
        logic                       ssat;
        logic                       deg;
    } side_t;
endpackage
`default_nettype wire

[hdl/tca_geom.sv]
// edge vectors, cross products, triple product and center numerators
`default_nettype none
module tca_geom (
    input  logic                        clk,
    input  logic                        en,
    input  tca_pkg::coord_t             pt [4][3],
    input  logic [tca_pkg::EPS_W-1:0]   eps,
    output tca_pkg::gm_out_t            res
);
    import tca_pkg::*;

    dif_t    e_reg [3][3];
    dif_t    e_next [3][3];
    prd_t    pa_reg [3][3];
    prd_t    pa_next [3][3];
    prd_t    pb_reg [3][3];
    prd_t    pb_next [3][3];
    prd_t    sq_reg [3][3];
    prd_t    sq_next [3][3];
    dif_t    u2_reg [3];
    crs_t    cr_reg [3][3];
    crs_t    cr_next [3][3];
    logic [LW-1:0] len_reg [3];
    logic [LW-1:0] len_next [3];
    dif_t    u3_reg [3];
    pp_t     th_reg [3];
    pp_t     th_next [3];
    pp_t     tl_reg [3];
    pp_t     tl_next [3];
    pp_t     hh_reg [3][3];
    pp_t     hh_next [3][3];
    pp_t     hl_reg [3][3];
    pp_t     hl_next [3][3];
    pp_t     lh_reg [3][3];
    pp_t     lh_next [3][3];
    pp_t     ll_reg [3][3];
    pp_t     ll_next [3][3];
    tri_t    tc_reg [3];
    tri_t    tc_next [3];
    nsum_t   nt_reg [3][3];
    nsum_t   nt_next [3][3];
    tri_t    t_reg;
    tri_t    t_next;
    nsum_t   n_reg [3];
    nsum_t   n_next [3];
    logic [TW-1:0] at_reg;
    logic [TW-1:0] at_next;
    logic    tneg_reg;
    logic [NW-1:0] na_reg [3];
    logic [NW-1:0] na_next [3];
    logic [2:0] ns_reg;
    gm_out_t out_reg;
    gm_out_t out_next;

    // stage 1: edge vectors from the first vertex
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_next[j][k] = DW'(pt[j + 1][k]) - DW'(pt[0][k]);
            end
        end
    end

    // stage 2: cross product terms and squares
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_next[j][k] = PRW'(e_reg[NX1[j]][NX1[k]]) * PRW'(e_reg[NX2[j]][NX2[k]]);
                pb_next[j][k] = PRW'(e_reg[NX1[j]][NX2[k]]) * PRW'(e_reg[NX2[j]][NX1[k]]);
                sq_next[j][k] = PRW'(e_reg[j][k]) * PRW'(e_reg[j][k]);
            end
        end
    end

    // stage 3: cross products (v x w, w x u, u x v) and squared lengths
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            len_next[j] = $unsigned(sq_reg[j][0]) + $unsigned(sq_reg[j][1])
                        + $unsigned(sq_reg[j][2]);
            for (int k = 0; k < 3; k++)
            begin
                cr_next[j][k] = pa_reg[j][k] - pb_reg[j][k];
            end
        end
    end

    // stage 4: split products, cross product high halves signed, all other halves unsigned
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            th_next[k] = PPW'(u3_reg[k]) * PPW'($signed(cr_reg[0][k][XW-1:DW]));
            tl_next[k] = PPW'(u3_reg[k]) * PPW'($signed({1'b0, cr_reg[0][k][DW-1:0]}));
        end
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hh_next[j][k] = PPW'($signed({1'b0, len_reg[j][LW-1:DW]}))
                              * PPW'($signed(cr_reg[j][k][XW-1:DW]));
                hl_next[j][k] = PPW'($signed({1'b0, len_reg[j][LW-1:DW]}))
                              * PPW'($signed({1'b0, cr_reg[j][k][DW-1:0]}));
                lh_next[j][k] = PPW'($signed({1'b0, len_reg[j][DW-1:0]}))
                              * PPW'($signed(cr_reg[j][k][XW-1:DW]));
                ll_next[j][k] = PPW'($signed({1'b0, len_reg[j][DW-1:0]}))
                              * PPW'($signed({1'b0, cr_reg[j][k][DW-1:0]}));
            end
        end
    end

    // stage 5: recombine partial products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tc_next[k] = (TW'(th_reg[k]) <<< DW) + TW'(tl_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nt_next[j][k] = (NW'(hh_reg[j][k]) <<< (2 * DW))
                              + ((NW'(hl_reg[j][k]) + NW'(lh_reg[j][k])) <<< DW)
                              + NW'(ll_reg[j][k]);
            end
        end
    end

    // stage 6: triple product and numerators
    always_comb
    begin
        t_next = tc_reg[0] + tc_reg[1] + tc_reg[2];
        for (int k = 0; k < 3; k++)
        begin
            n_next[k] = nt_reg[0][k] + nt_reg[1][k] + nt_reg[2][k];
        end
    end

    // stage 7: magnitudes
    always_comb
    begin
        at_next = t_reg[TW-1] ? $unsigned(-t_reg) : $unsigned(t_reg);
        for (int k = 0; k < 3; k++)
        begin
            na_next[k] = n_reg[k][NW-1] ? $unsigned(-n_reg[k]) : $unsigned(n_reg[k]);
        end
    end

    // stage 8: degeneracy, rounded dividend, divisor and quotient sign
    always_comb
    begin
        out_next.deg = (at_reg == '0)
                    || ((DGW'(at_reg) << EPS_FRAC) < (DGW'(eps) << (3 * FRAC_BITS)));
        out_next.den = {at_reg, 1'b0};
        for (int k = 0; k < 3; k++)
        begin
            out_next.num[k] = RW'(na_reg[k]) + RW'(at_reg);
            out_next.neg[k] = ns_reg[k] ^ tneg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg    <= e_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            sq_reg   <= sq_next;
            u2_reg   <= e_reg[0];
            cr_reg   <= cr_next;
            len_reg  <= len_next;
            u3_reg   <= u2_reg;
            th_reg   <= th_next;
            tl_reg   <= tl_next;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            lh_reg   <= lh_next;
            ll_reg   <= ll_next;
            tc_reg   <= tc_next;
            nt_reg   <= nt_next;
            t_reg    <= t_next;
            n_reg    <= n_next;
            at_reg   <= at_next;
            tneg_reg <= t_reg[TW-1];
            na_reg   <= na_next;
            ns_reg   <= {n_reg[2][NW-1], n_reg[1][NW-1], n_reg[0][NW-1]};
            out_reg  <= out_next;
        end
    end

    assign res = out_reg;
endmodule
`default_nettype wire

[hdl/tca_div.sv]
// pipelined restoring divider, one quotient bit per stage, clamped signed offset
`default_nettype none
module tca_div (
    input  logic            clk,
    input  logic            en,
    input  tca_pkg::rem_t   num,
    input  tca_pkg::den_t   den,
    input  logic            neg,
    output tca_pkg::off_t   q
);
    import tca_pkg::*;

    rem_t rem_reg [QB+1];
    quo_t quo_reg [QB+1];
    den_t den_reg [QB+1];
    logic ovf_reg [QB+1];
    logic neg_reg [QB+1];
    off_t q_reg;
    off_t q_next;
    quo_t mag;

    // quotient would not fit: clamp at the end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= num >= (RW'(den) << QB);
            neg_reg[0] <= neg;
        end
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        localparam int B = QB - i;
        rem_t trial;

        assign trial = RW'(den_reg[i-1]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[i-1] >= trial)
                begin
                    rem_reg[i] <= rem_reg[i-1] - trial;
                    quo_reg[i] <= quo_reg[i-1] | (quo_t'(1) << B);
                end
                else
                begin
                    rem_reg[i] <= rem_reg[i-1];
                    quo_reg[i] <= quo_reg[i-1];
                end
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[QB] || (quo_reg[QB] > OFF_LIM))
        begin
            mag = OFF_LIM;
        end
        else
        begin
            mag = quo_reg[QB];
        end
        q_next = neg_reg[QB] ? -off_t'(mag) : off_t'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

[hdl/tca_sqrt.sv]
// pipelined digit-by-digit floor square root, one result bit per stage
`default_nettype none
module tca_sqrt (
    input  logic                                clk,
    input  logic                                en,
    input  logic [tca_pkg::SQW-1:0]             s,
    output logic [tca_pkg::COORD_BITS-1:0]      root
);
    import tca_pkg::*;

    logic [OW-1:0] op_reg [SQ_LAT];
    logic [OW-1:0] rs_reg [SQ_LAT];

    for (genvar k = 0; k < SQ_LAT; k++)
    begin : g_bit
        localparam logic [OW-1:0] ONE = OW'(1) << (2 * (COORD_BITS - 1 - k));
        logic [OW-1:0] op_in;
        logic [OW-1:0] rs_in;
        logic [OW-1:0] sum;

        if (k == 0)
        begin : g_first
            assign op_in = OW'(s);
            assign rs_in = '0;
        end
        else
        begin : g_next
            assign op_in = op_reg[k-1];
            assign rs_in = rs_reg[k-1];
        end

        assign sum = rs_in + ONE;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (op_in >= sum)
                begin
                    op_reg[k] <= op_in - sum;
                    rs_reg[k] <= (rs_in >> 1) + ONE;
                end
                else
                begin
                    op_reg[k] <= op_in;
                    rs_reg[k] <= rs_in >> 1;
                end
            end
        end
    end

    assign root = rs_reg[SQ_LAT-1][COORD_BITS-1:0];
endmodule
`default_nettype wire

[hdl/tetra_circumsphere_alpha_test.sv]
// Circumsphere of a tetrahedron with degeneracy and alpha-radius tests.
// Input stream s_*: one request per tetrahedron, four vertices a..d as signed
// Q16.8 x, y, z coordinates packed in s_tdata. Output stream m_*: one result
// per request, center and radius in m_tdata, flags in m_tuser.
// Configuration channel cfg_*: index 0 alpha_radius, 1 epsilon_volume; any
// other index is ignored. cfg_ready is always high; write only while idle.
// Throughput: one request per cycle unless the output stalls, fully pipelined, no iteration.
// Pipeline: products and sums, then the divider (one quotient bit per stage
// for 26 bits, plus overflow check and sign), center clipping and squared
// radius, square root (one root bit per stage), and the output register.
// Stall: every stage advances on one enable; while a result waits with
// m_tready low the whole pipeline holds and s_tready is low.
// Reset: clears valid bits and restores alpha 1.0 and epsilon 16777 / 2^24.
`default_nettype none
module tetra_circumsphere_alpha_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z
    input  logic [tca_pkg::IN_W-1:0]            s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // center_x, center_y, center_z, radius
    output logic [tca_pkg::OUT_W-1:0]           m_tdata,
    // is_valid, within_alpha, saturated
    output logic [tca_pkg::USR_W-1:0]           m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tca_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [tca_pkg::EPS_W-1:0]           cfg_data
);
    import tca_pkg::*;

    localparam int P0D = GM_LAT + DIV_LAT;

    logic en;
    logic [TL-1:0] vld_reg;
    logic [COORD_BITS-1:0] alpha_reg;
    logic [EPS_W-1:0] eps_reg;

    coord_t pt [4][3];
    coord_t p0_reg [P0D][3];
    logic   deg_reg [DIV_LAT];
    gm_out_t gm;
    off_t   q [3];

    logic signed [SW-1:0] sq1_reg [3];
    logic signed [SW-1:0] sq1_next [3];
    logic [COORD_BITS-1:0] cen1_reg [3];
    logic [COORD_BITS-1:0] cen1_next [3];
    logic csat1_reg;
    logic csat1_next;
    logic deg1_reg;

    logic [SW-1:0] s2_reg;
    logic [SW-1:0] s2_next;
    side_t side2_reg;
    side_t side2_next;
    side_t sd_reg [SQ_LAT];
    logic [COORD_BITS-1:0] root;

    logic [OUT_W-1:0] tdata_reg;
    logic [OUT_W-1:0] tdata_next;
    logic [USR_W-1:0] tuser_reg;
    logic [USR_W-1:0] tuser_next;
    logic [COORD_BITS-1:0] rad;
    off_t c;

    localparam off_t CEN_HI = off_t'({1'b0, {(COORD_BITS - 1){1'b1}}});
    localparam off_t CEN_LO = off_t'($signed({1'b1, {(COORD_BITS - 1){1'b0}}}));

    assign en        = !vld_reg[TL-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[TL-1];
    assign m_tdata   = tdata_reg;
    assign m_tuser   = tuser_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            eps_reg   <= EPS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ALPHA: alpha_reg <= cfg_data[COORD_BITS-1:0];
                CFG_EPS:   eps_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TL-2:0], s_tvalid};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pt[i][k] = $signed(s_tdata[(3 * i + k) * COORD_BITS +: COORD_BITS]);
            end
        end
    end

    tca_geom u_geom (
        .clk (clk),
        .en  (en),
        .pt  (pt),
        .eps (eps_reg),
        .res (gm)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        tca_div u_div (
            .clk (clk),
            .en  (en),
            .num (gm.num[k]),
            .den (gm.den),
            .neg (gm.neg[k]),
            .q   (q[k])
        );
    end

    // first vertex and degeneracy flag ride alongside the math
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg[0] <= pt[0];
            for (int i = 1; i < P0D; i++)
            begin
                p0_reg[i] <= p0_reg[i-1];
            end
            deg_reg[0] <= gm.deg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                deg_reg[i] <= deg_reg[i-1];
            end
        end
    end

    // center clipping and squared offsets
    always_comb
    begin
        csat1_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            sq1_next[k] = SW'(q[k]) * SW'(q[k]);
            c = off_t'(p0_reg[P0D-1][k]) + q[k];
            if (c > CEN_HI)
            begin
                c = CEN_HI;
                csat1_next = 1'b1;
            end
            else if (c < CEN_LO)
            begin
                c = CEN_LO;
                csat1_next = 1'b1;
            end
            cen1_next[k] = c[COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        s2_next = $unsigned(sq1_reg[0]) + $unsigned(sq1_reg[1]) + $unsigned(sq1_reg[2]);
        side2_next.cen  = {cen1_reg[2], cen1_reg[1], cen1_reg[0]};
        side2_next.csat = csat1_reg;
        side2_next.ssat = s2_next >= (SW'(1) << (2 * COORD_BITS));
        side2_next.deg  = deg1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg   <= sq1_next;
            cen1_reg  <= cen1_next;
            csat1_reg <= csat1_next;
            deg1_reg  <= deg_reg[DIV_LAT-1];
            s2_reg    <= s2_next;
            side2_reg <= side2_next;
            sd_reg[0] <= side2_reg;
            for (int i = 1; i < SQ_LAT; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    tca_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .s    (s2_reg[SQW-1:0]),
        .root (root)
    );

    always_comb
    begin
        rad = sd_reg[SQ_LAT-1].ssat ? '1 : root;
        if (sd_reg[SQ_LAT-1].deg)
        begin
            tdata_next = '0;
            tuser_next = '0;
        end
        else
        begin
            tdata_next = OUT_W'({rad, sd_reg[SQ_LAT-1].cen});
            tuser_next[FLG_VALID] = 1'b1;
            tuser_next[FLG_ALPHA] = !sd_reg[SQ_LAT-1].ssat && (root <= alpha_reg);
            tuser_next[FLG_SAT]   = sd_reg[SQ_LAT-1].csat || sd_reg[SQ_LAT-1].ssat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[FLG_VALID] |-> m_tdata == '0 && m_tuser == '0)
        else $error("degenerate result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[FLG_ALPHA] |-> m_tuser[FLG_VALID])
        else $error("alpha keep flag on an invalid result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[FLG_SAT] |-> m_tuser[FLG_VALID])
        else $error("saturation flag on an invalid result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while the pipeline is stalled");
`endif
endmodule
`default_nettype wire
